/* hdl/vcmg_pkg.sv */
// ----------------------------------------------------------------------------
// vcmg_pkg: shared types and constants for the voxel column mean grid
// Holds sizes, status codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package vcmg_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;
    localparam int COORD_BITS = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Datapath operation codes issued by the controller.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;  // zero one accumulator cell
    localparam logic [2:0] OP_READ  = 3'd3;  // read one stored point
    localparam logic [2:0] OP_ACC   = 3'd4;  // add read point into its cell
    localparam logic [2:0] OP_CELL  = 3'd5;  // read one accumulator cell
    localparam logic [2:0] OP_DIV   = 3'd6;  // start the divider

    typedef struct packed {
        logic [2:0] op;
        logic       new_set;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

/* hdl/vcmg_div.sv */
// ----------------------------------------------------------------------------
// vcmg_div: signed 44-by-13 divider, one quotient bit per cycle
// Truncates toward zero; runs three lanes (x, y, z) in parallel.
// ----------------------------------------------------------------------------
`default_nettype none
module vcmg_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [2:0][43:0]   i_num,
    input  wire logic [12:0]        i_den,
    output logic                    o_done,
    output logic [2:0][31:0]        o_quot
);
    logic [2:0][43:0] r_q, n_q;
    logic [2:0][44:0] r_rem, n_rem;
    logic [2:0]       r_neg;
    logic [12:0]      r_den;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [2:0][44:0] trial;
    logic [2:0][43:0] qneg;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        for (int k = 0; k < 3; k++) begin
            trial[k] = {r_rem[k][43:0], r_q[k][43]} - {32'd0, r_den};
            qneg[k]  = -r_q[k];
        end
        if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                if (!trial[k][44]) begin
                    n_rem[k] = trial[k];
                    n_q[k]   = {r_q[k][42:0], 1'b1};
                end else begin
                    n_rem[k] = {r_rem[k][43:0], r_q[k][43]};
                    n_q[k]   = {r_q[k][42:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd44;
            end else begin
                r_busy <= n_busy;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= i_num[k][43];
                r_q[k]   <= i_num[k][43] ? -i_num[k] : i_num[k];
                r_rem[k] <= '0;
            end
            r_den <= i_den;
        end else begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_quot[k] = r_neg[k] ? qneg[k][31:0] : r_q[k][31:0];
        end
    end
endmodule
`default_nettype wire

/* hdl/vcmg_datapath.sv */
// ----------------------------------------------------------------------------
// vcmg_datapath: point buffer, bounding box, cell accumulators and divider
// Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module vcmg_datapath #(
    parameter int MAX_POINTS = vcmg_pkg::MAX_POINTS,
    parameter int GRID_ROWS  = vcmg_pkg::GRID_ROWS,
    parameter int GRID_COLS  = vcmg_pkg::GRID_COLS,
    parameter int COORD_BITS = vcmg_pkg::COORD_BITS,
    parameter int PW         = $clog2(MAX_POINTS + 1),
    parameter int CW         = $clog2(GRID_ROWS * GRID_COLS + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire vcmg_pkg::t_cmd        i_cmd,
    input  wire logic [PW-1:0]         i_paddr,
    input  wire logic [CW-1:0]         i_caddr,
    input  wire logic [15:0]           i_cell_x,
    input  wire logic [15:0]           i_cell_y,
    input  wire logic [31:0]           i_point_x,
    input  wire logic [31:0]           i_point_y,
    input  wire logic [31:0]           i_point_z,
    output logic [COORD_BITS:0]        o_w,
    output logic [COORD_BITS:0]        o_h,
    output logic                       o_pt_in,   // always high; size check keeps points in grid
    output logic [CW-1:0]              o_pt_idx,
    output logic                       o_cell_empty,
    output logic [2:0][31:0]           o_mean,
    output vcmg_pkg::t_stat            o_stat
);
    localparam int NP = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NC = GRID_ROWS * GRID_COLS;
    localparam int CI = (NC > 1) ? $clog2(NC) : 1;
    localparam int CB = COORD_BITS;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    logic [2*CB-1:0] pos_mem [MAX_POINTS];
    logic [95:0]     pt_mem  [MAX_POINTS];
    logic [131:0]    sum_mem [NC];
    logic [12:0]     cnt_mem [NC];

    logic signed [CB-1:0] r_minx, r_miny, r_maxx, r_maxy;
    logic [2*CB-1:0] r_pos;
    logic [95:0]     r_pt;
    logic [131:0]    r_sum;
    logic [12:0]     r_cnt;
    logic            r_acc_v;
    logic [CI-1:0]   r_acc_idx;
    logic [95:0]     r_acc_pt;
    logic signed [CB-1:0] cx, cy;
    logic signed [CB+1:0] dx, dy;
    logic [2*CB+4:0] idx_full;
    logic [NP-1:0]   pa;
    logic [CI-1:0]   ca;

    assign pa = i_paddr[NP-1:0];
    assign ca = i_caddr[CI-1:0];
    assign cx = i_cell_x[CB-1:0];
    assign cy = i_cell_y[CB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minx <= CMAX; r_miny <= CMAX;
            r_maxx <= CMIN; r_maxy <= CMIN;
        end else if (i_cmd.op == vcmg_pkg::OP_LOAD) begin
            if (i_cmd.new_set) begin
                r_minx <= cx; r_maxx <= cx; r_miny <= cy; r_maxy <= cy;
            end else begin
                if (cx < r_minx) r_minx <= cx;
                if (cx > r_maxx) r_maxx <= cx;
                if (cy < r_miny) r_miny <= cy;
                if (cy > r_maxy) r_maxy <= cy;
            end
        end
    end

    assign o_w = CB'(r_maxx - r_minx) + (CB+1)'(1);
    assign o_h = CB'(r_maxy - r_miny) + (CB+1)'(1);

    // Point buffer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == vcmg_pkg::OP_LOAD) begin
            pos_mem[pa] <= {cy, cx};
            pt_mem[pa]  <= {i_point_z, i_point_y, i_point_x};
        end
        r_pos <= pos_mem[pa];
        r_pt  <= pt_mem[pa];
    end

    // Cell index of the point just read; the grid fits by the size check.
    assign dx = (CB+2)'($signed(r_pos[CB-1:0])) - (CB+2)'(r_minx);
    assign dy = (CB+2)'($signed(r_pos[2*CB-1:CB])) - (CB+2)'(r_miny);
    assign idx_full = (2*CB+5)'(dx[CB:0] * o_h) + (2*CB+5)'(dy[CB:0]);
    assign o_pt_in  = 1'b1;
    assign o_pt_idx = CW'(idx_full);

    // Accumulators: read-modify-write, one point at a time.
    // The read data is held between reads so the cell count stays valid
    // until the result beat is shown.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == vcmg_pkg::OP_CLEAR) begin
            sum_mem[ca] <= '0;
            cnt_mem[ca] <= '0;
        end else if (r_acc_v) begin
            sum_mem[r_acc_idx] <= {
                r_sum[131:88] + {{12{r_acc_pt[95]}}, r_acc_pt[95:64]},
                r_sum[87:44]  + {{12{r_acc_pt[63]}}, r_acc_pt[63:32]},
                r_sum[43:0]   + {{12{r_acc_pt[31]}}, r_acc_pt[31:0]}};
            cnt_mem[r_acc_idx] <= r_cnt + 13'd1;
        end
        if (i_cmd.op == vcmg_pkg::OP_ACC || i_cmd.op == vcmg_pkg::OP_CELL) begin
            r_sum <= sum_mem[ca];
            r_cnt <= cnt_mem[ca];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
        end else begin
            r_acc_v <= (i_cmd.op == vcmg_pkg::OP_ACC);
        end
        r_acc_idx <= ca;
        r_acc_pt  <= r_pt;
    end

    assign o_cell_empty = (r_cnt == 13'd0);

    vcmg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == vcmg_pkg::OP_DIV),
        .i_num   ({r_sum[131:88], r_sum[87:44], r_sum[43:0]}),
        .i_den   (r_cnt),
        .o_done  (o_stat.div_done),
        .o_quot  (o_mean)
    );
endmodule
`default_nettype wire

/* hdl/vcmg_ctrl.sv */
// ----------------------------------------------------------------------------
// vcmg_ctrl: sequencer for loading, binning and per-cell fetch
// Runs the clear and bin sweeps and drives one result per fetch.
// ----------------------------------------------------------------------------
`default_nettype none
module vcmg_ctrl #(
    parameter int MAX_POINTS = vcmg_pkg::MAX_POINTS,
    parameter int GRID_ROWS  = vcmg_pkg::GRID_ROWS,
    parameter int GRID_COLS  = vcmg_pkg::GRID_COLS,
    parameter int COORD_BITS = vcmg_pkg::COORD_BITS,
    parameter int PW         = $clog2(MAX_POINTS + 1),
    parameter int CW         = $clog2(GRID_ROWS * GRID_COLS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_mode,
    input  wire logic [COORD_BITS:0] i_w,
    input  wire logic [COORD_BITS:0] i_h,
    input  wire logic [CW-1:0]      i_pt_idx,
    input  wire vcmg_pkg::t_stat    i_stat,
    output vcmg_pkg::t_cmd          o_cmd,
    output logic [PW-1:0]           o_paddr,
    output logic [CW-1:0]           o_caddr,
    output logic                    o_valid,
    output logic                    o_err,
    output logic [1:0]              o_status,
    output logic [5:0]              o_row,
    output logic [5:0]              o_col,
    output logic                    o_last
);
    localparam int NC = GRID_ROWS * GRID_COLS;
    localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_RD = 3'd2,
        S_ACC = 3'd3, S_CELL = 3'd4, S_DIV = 3'd5, S_WAIT = 3'd6,
        S_DRAIN = 3'd7;
    localparam logic [1:0] PH_LOAD = 2'd0, PH_FETCH = 2'd1, PH_DONE = 2'd2;

    logic [2:0]    r_state;
    logic [1:0]    r_phase;
    logic [PW-1:0] r_count, r_ptr;
    logic [CW-1:0] r_cidx, r_fetch;
    logic [CW-1:0] r_cells;
    logic [10:0]   r_row, r_col;
    logic          r_ovf;
    logic [1:0]    chk;
    logic [2*COORD_BITS+1:0] wh;

    assign busy = (r_state != S_IDLE);
    assign wh   = i_w * i_h;

    always_comb begin
        if (r_count == '0)                 chk = vcmg_pkg::ST_EMPTY;
        else if (r_ovf)                    chk = vcmg_pkg::ST_OVERFLOW;
        else if (i_w > (COORD_BITS+1)'(GRID_ROWS) || i_h > (COORD_BITS+1)'(GRID_COLS))
            chk = vcmg_pkg::ST_TOO_BIG;
        else                               chk = vcmg_pkg::ST_OK;
    end

    always_comb begin
        o_cmd   = '{op: vcmg_pkg::OP_NONE, new_set: (r_phase != PH_LOAD)};
        o_paddr = r_ptr;
        o_caddr = r_cidx;
        if (r_state == S_IDLE && start && !i_mode && r_phase == PH_LOAD &&
            r_count < PW'(MAX_POINTS)) begin
            o_cmd.op = vcmg_pkg::OP_LOAD;
            o_paddr  = r_count;
        end else if (r_state == S_IDLE && start && !i_mode && r_phase != PH_LOAD) begin
            o_cmd.op = vcmg_pkg::OP_LOAD;
            o_paddr  = '0;
        end else begin
            case (r_state)
                S_CLR:  o_cmd.op = vcmg_pkg::OP_CLEAR;
                S_RD:   o_cmd.op = vcmg_pkg::OP_READ;
                S_ACC: begin
                    o_cmd.op = vcmg_pkg::OP_ACC;
                    o_caddr  = i_pt_idx;
                end
                S_CELL: begin
                    o_cmd.op = vcmg_pkg::OP_CELL;
                    o_caddr  = r_fetch;
                end
                S_DIV:  o_cmd.op = vcmg_pkg::OP_DIV;
                default: o_cmd.op = vcmg_pkg::OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= PH_LOAD; r_count <= '0; r_ovf <= 1'b0;
            r_ptr <= '0; r_cidx <= '0; r_fetch <= '0; r_cells <= '0;
            r_row <= '0; r_col <= '0; o_valid <= 1'b0; o_err <= 1'b0;
            o_status <= '0; o_row <= '0; o_col <= '0; o_last <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start && !i_mode) begin
                        if (r_phase != PH_LOAD) begin
                            r_phase <= PH_LOAD; r_count <= PW'(1); r_ovf <= 1'b0;
                        end else if (r_count < PW'(MAX_POINTS)) begin
                            r_count <= r_count + PW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else if (start && i_mode) begin
                        if (r_phase == PH_FETCH) begin
                            r_state <= S_CELL;
                        end else if (chk != vcmg_pkg::ST_OK) begin
                            o_valid <= 1'b1; o_err <= 1'b1; o_status <= chk;
                            o_row <= '0; o_col <= '0; o_last <= 1'b1;
                            r_phase <= PH_DONE;
                        end else begin
                            r_cells <= CW'(wh);
                            r_cidx <= '0; r_state <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    r_cidx <= r_cidx + CW'(1);
                    if (r_cidx == CW'(NC - 1)) begin
                        r_ptr <= '0; r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_ptr <= r_ptr + PW'(1);
                    if (r_ptr + PW'(1) >= r_count) begin
                        r_phase <= PH_FETCH; r_fetch <= '0;
                        r_row <= '0; r_col <= '0; r_state <= S_DRAIN;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                // Lets the last accumulator write land before the first cell read.
                S_DRAIN: r_state <= S_CELL;
                S_CELL: r_state <= S_DIV;
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_stat.div_done) begin
                        o_valid <= 1'b1; o_err <= 1'b0; o_status <= vcmg_pkg::ST_OK;
                        o_row <= r_row[5:0]; o_col <= r_col[5:0];
                        o_last <= (r_fetch + CW'(1) >= r_cells);
                        r_state <= S_IDLE;
                        if (r_fetch + CW'(1) >= r_cells) begin
                            r_phase <= PH_DONE; r_fetch <= '0;
                        end else begin
                            r_fetch <= r_fetch + CW'(1);
                            if (11'(r_col) + 11'd1 == 11'(i_h)) begin
                                r_col <= '0; r_row <= r_row + 11'd1;
                            end else begin
                                r_col <= r_col + 11'd1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/voxel_column_mean_grid_top.sv */
// ----------------------------------------------------------------------------
// voxel_column_mean_grid_top: per-cell mean of voxel points on a 2-D grid
// Loads voxels into a buffer, bins them on the first fetch, returns cell means.
// ----------------------------------------------------------------------------
// A load gives no result. The first fetch of a set clears every accumulator
// cell, then bins each stored point with a read and an accumulate state and
// drains the last write; each fetch then reads its cell and runs the 44-step
// divider. The result beat is shown for one cycle and cannot be stalled.
// Synchronous active-low reset starts an empty set; buffers need no clearing.
`default_nettype none
module voxel_column_mean_grid_top #(
    parameter int MAX_POINTS = vcmg_pkg::MAX_POINTS,
    parameter int GRID_ROWS  = vcmg_pkg::GRID_ROWS,
    parameter int GRID_COLS  = vcmg_pkg::GRID_COLS,
    parameter int COORD_BITS = vcmg_pkg::COORD_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_cell_x,
    input  wire logic [15:0] i_cell_y,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    input  wire logic [31:0] i_point_z,
    output logic             o_valid,
    output logic [31:0]      o_mean_x,
    output logic [31:0]      o_mean_y,
    output logic [31:0]      o_mean_z,
    output logic             o_cell_empty,
    output logic [5:0]       o_grid_row,
    output logic [5:0]       o_grid_col,
    output logic             o_last_cell,
    output logic [1:0]       o_status
);
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(GRID_ROWS * GRID_COLS + 1);

    vcmg_pkg::t_cmd  cmd;
    vcmg_pkg::t_stat stat;
    logic [PW-1:0] paddr;
    logic [CW-1:0] caddr, pt_idx;
    logic [COORD_BITS:0] w, h;
    logic pt_in, empty, err;
    logic [2:0][31:0] mean;

    vcmg_ctrl #(.MAX_POINTS(MAX_POINTS), .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS), .COORD_BITS(COORD_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_w(w), .i_h(h), .i_pt_idx(pt_idx), .i_stat(stat),
        .o_cmd(cmd), .o_paddr(paddr), .o_caddr(caddr), .o_valid(o_valid),
        .o_err(err), .o_status(o_status), .o_row(o_grid_row),
        .o_col(o_grid_col), .o_last(o_last_cell));

    vcmg_datapath #(.MAX_POINTS(MAX_POINTS), .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_paddr(paddr),
        .i_caddr(caddr), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .o_w(w), .o_h(h), .o_pt_in(pt_in), .o_pt_idx(pt_idx),
        .o_cell_empty(empty), .o_mean(mean), .o_stat(stat));

    // Empty cells and error beats report the most negative mean.
    always_comb begin
        o_cell_empty = err | empty | ~pt_in;
        o_mean_x = o_cell_empty ? 32'h8000_0000 : mean[0];
        o_mean_y = o_cell_empty ? 32'h8000_0000 : mean[1];
        o_mean_z = o_cell_empty ? 32'h8000_0000 : mean[2];
    end
endmodule
`default_nettype wire
